[hdl/cpdt_pkg.sv]
// ----------------------------------------------------------------------------
// cpdt_pkg
// Shared types and constants for the clutched pose-delta teleop block.
// ----------------------------------------------------------------------------
package cpdt_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam logic signed [23:0] HALF_PI_Q16 = 24'sd102944;
	localparam logic signed [15:0] PI_Q13 = 16'sd25736;
	localparam logic signed [15:0] HALF_PI_Q13 = 16'sd12868;

	typedef enum logic {
		REG_GRIP_THRESHOLD = 1'b0,
		REG_POSITION_SCALE = 1'b1
	} reg_idx_t;

	function automatic logic [15:0] atan_entry(input logic [3:0] i);
		case (i)
			4'd0:    atan_entry = 16'd51472;
			4'd1:    atan_entry = 16'd30386;
			4'd2:    atan_entry = 16'd16055;
			4'd3:    atan_entry = 16'd8150;
			4'd4:    atan_entry = 16'd4091;
			4'd5:    atan_entry = 16'd2047;
			4'd6:    atan_entry = 16'd1024;
			4'd7:    atan_entry = 16'd512;
			4'd8:    atan_entry = 16'd256;
			4'd9:    atan_entry = 16'd128;
			4'd10:   atan_entry = 16'd64;
			4'd11:   atan_entry = 16'd32;
			4'd12:   atan_entry = 16'd16;
			4'd13:   atan_entry = 16'd8;
			4'd14:   atan_entry = 16'd4;
			default: atan_entry = 16'd2;
		endcase
	endfunction

endpackage

[hdl/clutched_pose_delta_teleop.sv]
// ----------------------------------------------------------------------------
// clutched_pose_delta_teleop
// Clutched position-delta target accumulator with quaternion-to-Euler angles.
// ----------------------------------------------------------------------------
// channel | dir | beat contents
// s_axis  | in  | tdata: pos_x,pos_y,pos_z,quat_x..quat_w,grip_level,trigger
// m_axis  | out | tdata: target_x,y,z,roll,pitch,yaw,gripper_open
// cfg     | in  | cfg_index selects register, cfg_data value
// A beat that gives no result is taken with s_axis_tready held high.
// A beat that gives one drops s_axis_tready; m_axis_tvalid rises after the
// scaled deltas, the quaternion products on the shared multiplier, a CORDIC
// pass each for pitch and roll (no iterations for a zero vector) and yaw (a
// 29-step square root, then CORDIC; neither when |s| clamps). s_axis_tready
// returns the cycle after the beat leaves; arst_n resets state, config, targets.
// ----------------------------------------------------------------------------
module clutched_pose_delta_teleop (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// [31:0] pos_x [63:32] pos_y [95:64] pos_z [111:96] quat_x [127:112] quat_y
	// [143:128] quat_z [159:144] quat_w [175:160] grip_level [176] trigger_pressed
	input  logic [183:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [31:0] target_x [63:32] target_y [95:64] target_z [111:96] roll_angle
	// [127:112] pitch_angle [142:128] yaw_angle [143] gripper_open
	output logic [143:0] m_axis_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic         cfg_index,
	input  logic [15:0]  cfg_data
);
	import cpdt_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_MUL, ST_ACC, ST_QMUL, ST_QSUM, ST_SQRT, ST_CPRE, ST_CITER,
		ST_CPOST, ST_OUT
	} state_t;

	state_t state_q;
	logic [15:0] thr_q, scale_q;
	logic was_pressed_q, need_baseline_q;
	logic signed [31:0] prev_q [3];
	logic signed [31:0] tgt_q [3];
	logic signed [31:0] pos_q [3];
	logic signed [15:0] qx_q, qy_q, qz_q, qw_q;
	logic trig_q;
	logic [3:0] cnt_q;
	logic [1:0] idx_q;
	logic signed [49:0] delta_q;
	logic signed [15:0] pa_q, pb_q;
	logic signed [35:0] acc_q [5];
	logic signed [40:0] cx_q, cy_q;
	logic signed [23:0] cz_q;
	logic signed [15:0] roll_q, pitch_q;
	logic signed [14:0] yaw_q;
	logic [1:0] pass_q;
	logic [3:0] qstep_q;

	// shared multiplier: signed 33x17
	logic signed [49:0] mul_w;
	logic signed [32:0] ma;
	logic signed [16:0] mb;
	always_comb begin
		ma = 33'sd0;
		mb = 17'sd0;
		if (state_q == ST_MUL) begin
			case (idx_q)
				2'd0:    ma = 33'(prev_q[2]) - 33'(pos_q[2]);
				2'd1:    ma = 33'(prev_q[0]) - 33'(pos_q[0]);
				default: ma = 33'(pos_q[1]) - 33'(prev_q[1]);
			endcase
			mb = {1'b0, scale_q};
		end else begin
			ma = {{17{pa_q[15]}}, pa_q};
			mb = {pb_q[15], pb_q};
		end
		mul_w = 50'(ma * mb);
	end

	logic signed [50:0] rnd_w;
	logic signed [33:0] sum_w;
	logic signed [31:0] sat_w;
	always_comb begin
		rnd_w = (51'(delta_q) + 51'sd2048) >>> 12;
		if (rnd_w > 51'sd4294967295)
			sum_w = 34'sd8589934591;
		else if (rnd_w < -51'sd4294967296)
			sum_w = -34'sd8589934592;
		else
			sum_w = 34'(tgt_q[idx_q]) + 34'(rnd_w[33:0]);
		if (sum_w > 34'sd2147483647)
			sat_w = 32'sh7FFFFFFF;
		else if (sum_w < -34'sd2147483648)
			sat_w = 32'sh80000000;
		else
			sat_w = sum_w[31:0];
	end

	// quaternion products: qstep selects pair, acc index
	// acc0 = wx+yz, acc1 = xx+yy, acc2 = wz+xy, acc3 = yy+zz, acc4 = wy-zx
	logic signed [15:0] opa, opb;
	logic [2:0] dst;
	logic neg;
	always_comb begin
		opa = qw_q; opb = qx_q; dst = 3'd0; neg = 1'b0;
		case (qstep_q)
			4'd0: begin opa = qw_q; opb = qx_q; dst = 3'd0; end
			4'd1: begin opa = qy_q; opb = qz_q; dst = 3'd0; end
			4'd2: begin opa = qx_q; opb = qx_q; dst = 3'd1; end
			4'd3: begin opa = qy_q; opb = qy_q; dst = 3'd1; end
			4'd4: begin opa = qw_q; opb = qz_q; dst = 3'd2; end
			4'd5: begin opa = qx_q; opb = qy_q; dst = 3'd2; end
			4'd6: begin opa = qy_q; opb = qy_q; dst = 3'd3; end
			4'd7: begin opa = qz_q; opb = qz_q; dst = 3'd3; end
			4'd8: begin opa = qw_q; opb = qy_q; dst = 3'd4; end
			default: begin opa = qz_q; opb = qx_q; dst = 3'd4; neg = 1'b1; end
		endcase
	end

	logic signed [35:0] prod_w;
	assign prod_w = 36'($signed(mul_w[33:0]));

	// s as Q.28 signed
	logic signed [36:0] s_w;
	logic [35:0] sabs_w;
	assign s_w = 37'(acc_q[4]) <<< 1;
	assign sabs_w = s_w[36] ? 36'(-s_w) : 36'(s_w);

	// cordic step
	logic signed [40:0] dx_w, dy_w;
	assign dx_w = cx_q >>> cnt_q;
	assign dy_w = cy_q >>> cnt_q;

	logic signed [23:0] zr_w;
	logic signed [20:0] q13_w;
	logic signed [15:0] lim_w, ang_w;
	always_comb begin
		zr_w = (cz_q + 24'sd4) >>> 3;
		q13_w = zr_w[20:0];
		lim_w = (pass_q == 2'd2) ? HALF_PI_Q13 : PI_Q13;
		if (q13_w > 21'(lim_w))
			ang_w = lim_w;
		else if (q13_w < -21'(lim_w))
			ang_w = -lim_w;
		else
			ang_w = q13_w[15:0];
	end

	// digit-recurrence square root of 2^56 - s^2, two radicand bits per cycle
	logic [57:0] rad_q;
	logic [5:0] sq_cnt_q;
	logic [29:0] sq_root_q;
	logic [59:0] sq_rem_q;
	logic [59:0] sq_try_w;
	assign sq_try_w = {sq_rem_q[57:0], rad_q[57:56]} - {28'd0, sq_root_q, 2'b01};

	logic pressed_w;
	assign pressed_w = s_axis_tdata[175:160] > thr_q;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			thr_q <= 16'd58982;
			scale_q <= 16'd4096;
			was_pressed_q <= 1'b0;
			need_baseline_q <= 1'b1;
			tgt_q[0] <= '0; tgt_q[1] <= '0; tgt_q[2] <= '0;
			m_axis_tvalid <= 1'b0;
			cnt_q <= '0; idx_q <= '0; pass_q <= '0; qstep_q <= '0;
			sq_cnt_q <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_GRIP_THRESHOLD: thr_q <= cfg_data;
					default:            scale_q <= cfg_data;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						pos_q[0] <= s_axis_tdata[31:0];
						pos_q[1] <= s_axis_tdata[63:32];
						pos_q[2] <= s_axis_tdata[95:64];
						qx_q <= s_axis_tdata[111:96];
						qy_q <= s_axis_tdata[127:112];
						qz_q <= s_axis_tdata[143:128];
						qw_q <= s_axis_tdata[159:144];
						trig_q <= s_axis_tdata[176];
						was_pressed_q <= pressed_w;
						if (!pressed_w || s_axis_tdata[31:0] == 32'd0) begin
							if (was_pressed_q && !pressed_w)
								need_baseline_q <= 1'b1;
						end else if (need_baseline_q && !(was_pressed_q && !pressed_w)) begin
							prev_q[0] <= s_axis_tdata[31:0];
							prev_q[1] <= s_axis_tdata[63:32];
							prev_q[2] <= s_axis_tdata[95:64];
							need_baseline_q <= 1'b0;
						end else begin
							idx_q <= 2'd0;
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					delta_q <= mul_w;
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					tgt_q[idx_q] <= sat_w;
					if (idx_q == 2'd2) begin
						prev_q <= pos_q;
						qstep_q <= '0;
						for (int k = 0; k < 5; k++) acc_q[k] <= '0;
						pa_q <= qw_q; pb_q <= qx_q;
						state_q <= ST_QMUL;
					end else begin
						idx_q <= idx_q + 2'd1;
						state_q <= ST_MUL;
					end
				end
				ST_QMUL: begin
					pa_q <= opa; pb_q <= opb;
					state_q <= ST_QSUM;
				end
				ST_QSUM: begin
					acc_q[dst] <= neg ? acc_q[dst] - prod_w : acc_q[dst] + prod_w;
					if (qstep_q == 4'd9) begin
						pass_q <= 2'd0;
						state_q <= ST_CPRE;
					end else begin
						qstep_q <= qstep_q + 4'd1;
						state_q <= ST_QMUL;
					end
				end
				ST_SQRT: begin
					rad_q <= rad_q << 2;
					if (!sq_try_w[59]) begin
						sq_rem_q <= sq_try_w;
						sq_root_q <= {sq_root_q[28:0], 1'b1};
					end else begin
						sq_rem_q <= {sq_rem_q[57:0], rad_q[57:56]};
						sq_root_q <= {sq_root_q[28:0], 1'b0};
					end
					if (sq_cnt_q == 6'd28) begin
						cx_q <= 41'({1'b0, sq_root_q[27:0], ~sq_try_w[59]});
						cy_q <= 41'(s_w);
						cz_q <= '0;
						cnt_q <= '0;
						state_q <= ST_CITER;
					end
					sq_cnt_q <= sq_cnt_q + 6'd1;
				end
				ST_CPRE: begin
					logic signed [40:0] x0, y0;
					x0 = 41'sd0; y0 = 41'sd0;
					case (pass_q)
						2'd0: begin
							y0 = 41'(acc_q[0]) <<< 1;
							x0 = 41'sd268435456 - (41'(acc_q[1]) <<< 1);
						end
						2'd1: begin
							y0 = 41'(acc_q[2]) <<< 1;
							x0 = 41'sd268435456 - (41'(acc_q[3]) <<< 1);
						end
						default: begin
							y0 = 41'(s_w);
							x0 = 41'sd0;
						end
					endcase
					if (pass_q == 2'd2) begin
						if (s_w >= 37'sd268435456) begin
							yaw_q <= HALF_PI_Q13[14:0];
							state_q <= ST_OUT;
							m_axis_tvalid <= 1'b1;
						end else if (s_w <= -37'sd268435456) begin
							yaw_q <= -HALF_PI_Q13[14:0];
							state_q <= ST_OUT;
							m_axis_tvalid <= 1'b1;
						end else begin
							rad_q <= 58'((57'd1 << 56) - 57'(sabs_w[27:0] * sabs_w[27:0]));
							sq_rem_q <= '0;
							sq_root_q <= '0;
							sq_cnt_q <= '0;
							state_q <= ST_SQRT;
						end
					end else if (x0 == 0 && y0 == 0) begin
						cx_q <= 41'sd1; cy_q <= 41'sd0;
						cz_q <= '0;
						cnt_q <= '0;
						state_q <= ST_CPOST;
					end else begin
						cnt_q <= '0;
						if (x0 < 0) begin
							if (y0 >= 0) begin
								cx_q <= y0; cy_q <= -x0; cz_q <= HALF_PI_Q16;
							end else begin
								cx_q <= -y0; cy_q <= x0; cz_q <= -HALF_PI_Q16;
							end
						end else begin
							cx_q <= x0; cy_q <= y0; cz_q <= '0;
						end
						state_q <= ST_CITER;
					end
				end
				ST_CITER: begin
					if (cy_q >= 0) begin
						cx_q <= cx_q + dy_w; cy_q <= cy_q - dx_w;
						cz_q <= cz_q + 24'(atan_entry(cnt_q));
					end else begin
						cx_q <= cx_q - dy_w; cy_q <= cy_q + dx_w;
						cz_q <= cz_q - 24'(atan_entry(cnt_q));
					end
					if (cnt_q == 4'(CORDIC_STEPS - 1))
						state_q <= ST_CPOST;
					cnt_q <= cnt_q + 4'd1;
				end
				ST_CPOST: begin
					case (pass_q)
						2'd0: pitch_q <= -ang_w;
						2'd1: roll_q <= -ang_w;
						default: yaw_q <= ang_w[14:0];
					endcase
					if (pass_q == 2'd2) begin
						m_axis_tvalid <= 1'b1;
						state_q <= ST_OUT;
					end else begin
						pass_q <= pass_q + 2'd1;
						state_q <= ST_CPRE;
					end
				end
				ST_OUT: begin
					if (m_axis_tready) begin
						m_axis_tvalid <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tdata = {~trig_q, yaw_q, pitch_q, roll_q,
		tgt_q[2], tgt_q[1], tgt_q[0]};

endmodule

[hdl/cpdt_checker.sv]
// ----------------------------------------------------------------------------
// cpdt_checker
// Port-level checks for the clutched pose-delta teleop block.
// ----------------------------------------------------------------------------
module cpdt_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [143:0] m_axis_tdata
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat dropped while stalled");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("input ready while result pending");
	a_no_twin: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
		else $error("result too early");
	a_yaw_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ($signed(m_axis_tdata[142:128]) <= 15'sd12868 &&
			$signed(m_axis_tdata[142:128]) >= -15'sd12868))
		else $error("yaw out of range");
endmodule

bind clutched_pose_delta_teleop cpdt_checker u_cpdt_checker (.*);
